// ===== sv/interrupt_controller_8259_macros.svh =====
// assertion macros for the interrupt controller
// used by the top level; needs clk and rst_n in scope at the point of use
`ifndef INTERRUPT_CONTROLLER_8259_MACROS_SVH
`define INTERRUPT_CONTROLLER_8259_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PIC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interrupt controller check failed");

// consequent must hold in the cycle after the antecedent
`define PIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interrupt controller check failed");

`endif

// ===== sv/pic8259_pkg.sv =====
// shared types and constants of the interrupt controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pic8259_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // item kinds
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINES = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  // init sequencer
  typedef enum logic [3:0] {
    PH_READY = 4'b0001,
    PH_ICW2  = 4'b0010,
    PH_ICW3  = 4'b0100,
    PH_ICW4  = 4'b1000
  } phase_t;

  localparam logic [7:0] CMD_ICW1       = 8'h10;
  localparam logic [7:0] CMD_OCW3       = 8'h08;
  localparam logic [7:0] ICW1_NEED_ICW4 = 8'h01;
  localparam logic [7:0] ICW1_SNGL      = 8'h02;
  localparam logic [7:0] OCW2_KIND_MASK = 8'he0;
  localparam logic [7:0] OCW2_SPEC_EOI  = 8'h60;
  localparam logic [7:0] OCW3_RR        = 8'h02;
  localparam logic [7:0] OCW3_SEL_ISR   = 8'h01;
  localparam logic [2:0] SPURIOUS_LINE  = 3'd7;

  typedef struct packed {
    op_t        op;
    logic       addr_bit;
    logic [7:0] write_data;
    logic [7:0] request_lines;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       int_out;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] line;
  } grant_t;

endpackage

`default_nettype wire

// ===== sv/pic8259_prio.sv =====
// priority resolver: lowest pending line that outranks every in-service line
// uses pic8259_pkg
`timescale 1ns / 1ps
`default_nettype none

module pic8259_prio
  import pic8259_pkg::*;
#(
  parameter int NUM_LINES = 8
) (
  input  wire logic [NUM_LINES-1:0] pend_i,
  input  wire logic [NUM_LINES-1:0] serv_i,
  output grant_t                    grant_o
);

  logic [3:0] p_idx;
  logic [3:0] s_idx;

  always_comb begin
    p_idx = 4'd8;
    s_idx = 4'd8;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (pend_i[i]) p_idx = 4'(i);
      if (serv_i[i]) s_idx = 4'(i);
    end
    grant_o.valid = (p_idx < s_idx);
    grant_o.line  = p_idx[2:0];
  end

endmodule

`default_nettype wire

// ===== sv/pic8259_core.sv =====
// controller state, per-item update and result register
// uses pic8259_pkg and pic8259_prio
`timescale 1ns / 1ps
`default_nettype none

module pic8259_core
  import pic8259_pkg::*;
#(
  parameter int NUM_LINES = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    take_i,
  input  wire item_t   item_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_o
);

  logic [NUM_LINES-1:0] req_r, req_nxt;
  logic [NUM_LINES-1:0] serv_r, serv_nxt;
  logic [7:0]           mask_r, mask_nxt;
  logic [4:0]           base_r, base_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 icw4_r, icw4_nxt;
  logic                 sngl_r, sngl_nxt;
  logic                 rsel_r, rsel_nxt;
  logic [NUM_LINES-1:0] prev_r, prev_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r;
  result_t              res;

  logic [NUM_LINES-1:0] lines;
  logic [7:0]           wd;
  grant_t               grant_now;
  grant_t               grant_after;

  assign lines = item_i.request_lines[NUM_LINES-1:0];
  assign wd    = item_i.write_data;

  pic8259_prio #(.NUM_LINES(NUM_LINES)) u_prio_now (
    .pend_i  (req_r & ~mask_r[NUM_LINES-1:0]),
    .serv_i  (serv_r),
    .grant_o (grant_now)
  );

  pic8259_prio #(.NUM_LINES(NUM_LINES)) u_prio_after (
    .pend_i  (req_nxt & ~mask_nxt[NUM_LINES-1:0]),
    .serv_i  (serv_nxt),
    .grant_o (grant_after)
  );

  always_comb begin
    req_nxt   = req_r;
    serv_nxt  = serv_r;
    mask_nxt  = mask_r;
    base_nxt  = base_r;
    phase_nxt = phase_r;
    icw4_nxt  = icw4_r;
    sngl_nxt  = sngl_r;
    rsel_nxt  = rsel_r;
    prev_nxt  = prev_r;
    res.read_data = '0;
    res.vector    = '0;
    case (item_i.op)
      OP_READ: begin
        if (item_i.addr_bit) res.read_data = mask_r;
        else if (rsel_r)     res.read_data = 8'(serv_r);
        else                 res.read_data = 8'(req_r);
      end
      OP_WRITE: begin
        if (!item_i.addr_bit) begin
          if ((wd & CMD_ICW1) != '0) begin
            phase_nxt = PH_ICW2;
            icw4_nxt  = ((wd & ICW1_NEED_ICW4) != '0);
            sngl_nxt  = ((wd & ICW1_SNGL) != '0);
            mask_nxt  = '0;
            req_nxt   = '0;
            serv_nxt  = '0;
            rsel_nxt  = 1'b0;
          end else if ((wd & CMD_OCW3) != '0) begin
            if ((wd & OCW3_RR) != '0) rsel_nxt = ((wd & OCW3_SEL_ISR) != '0);
          end else if ((wd & OCW2_KIND_MASK) == OCW2_SPEC_EOI) begin
            // levels beyond the implemented lines match nothing
            for (int i = 0; i < NUM_LINES; i++) begin
              if (3'(i) == wd[2:0]) serv_nxt[i] = 1'b0;
            end
          end
        end else begin
          case (phase_r)
            PH_ICW2: begin
              base_nxt  = wd[7:3];
              phase_nxt = sngl_r ? (icw4_r ? PH_ICW4 : PH_READY) : PH_ICW3;
            end
            PH_ICW3: phase_nxt = icw4_r ? PH_ICW4 : PH_READY;
            PH_ICW4: phase_nxt = PH_READY;
            default: mask_nxt = wd;
          endcase
        end
      end
      OP_LINES: begin
        req_nxt  = req_r | (lines & ~prev_r);
        prev_nxt = lines;
      end
      default: begin
        if (grant_now.valid) begin
          for (int i = 0; i < NUM_LINES; i++) begin
            if (3'(i) == grant_now.line) begin
              req_nxt[i]  = 1'b0;
              serv_nxt[i] = 1'b1;
            end
          end
          res.vector = {base_r, grant_now.line};
        end else begin
          res.vector = {base_r, SPURIOUS_LINE};
        end
      end
    endcase
    res.int_out = grant_after.valid;
  end

  assign ready_o       = !out_valid_r || out_ready_i;
  assign out_valid_nxt = take_i || (out_valid_r && !out_ready_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      serv_r      <= '0;
      mask_r      <= '0;
      base_r      <= '0;
      phase_r     <= PH_READY;
      icw4_r      <= 1'b0;
      sngl_r      <= 1'b0;
      rsel_r      <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take_i) begin
        req_r   <= req_nxt;
        serv_r  <= serv_nxt;
        mask_r  <= mask_nxt;
        base_r  <= base_nxt;
        phase_r <= phase_nxt;
        icw4_r  <= icw4_nxt;
        sngl_r  <= sngl_nxt;
        rsel_r  <= rsel_nxt;
        prev_r  <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_i) out_r <= res;
  end

  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;

endmodule

`default_nettype wire

// ===== sv/interrupt_controller_8259.sv =====
// top level of the 8259-style interrupt controller: input register and core
// uses pic8259_pkg, pic8259_core and interrupt_controller_8259_macros.svh
//
//   channel | direction | contents
//   in_     | slave     | bus read/write, request-line update or acknowledge
//   out_    | master    | read byte, acknowledge vector, interrupt level
//
// one item per cycle sustained while out_tready is high; a result is offered on out_
// after its input transfer, once the item has gone through the registers below
// (input register, then state update into the result register)
// rst_n is synchronous, active low; clears all controller state and both valids
// a stalled result holds in the result register while one more item waits in
// the input register; in_tready drops only when both are full and out_tready is low
`timescale 1ns / 1ps
`default_nettype none
`include "interrupt_controller_8259_macros.svh"

module interrupt_controller_8259
  import pic8259_pkg::*;
#(
  parameter int NUM_LINES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // addr_bit [0], write_data [8:1], request_lines [16:9], zero fill above
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op [1:0]
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // read_data [7:0], vector [15:8], int_out [16], zero fill above
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic    in_valid_r, in_valid_nxt;
  item_t   in_item_r;
  item_t   in_item;
  logic    core_ready;
  logic    core_take;
  result_t core_out;

  // unpack the incoming transfer
  assign in_item.op            = op_t'(in_tuser);
  assign in_item.addr_bit      = in_tdata[0];
  assign in_item.write_data    = in_tdata[8:1];
  assign in_item.request_lines = in_tdata[16:9];

  // the core consumes the buffered item whenever the result register is free or being emptied
  assign core_take    = in_valid_r && core_ready;
  assign in_tready    = !in_valid_r || core_take;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !core_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // payload register, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_item_r <= in_item;
  end

  pic8259_core #(.NUM_LINES(NUM_LINES)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (core_take),
    .item_i      (in_item_r),
    .ready_o     (core_ready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_o       (core_out)
  );

  // pack the result
  assign out_tdata = {7'b0, core_out.int_out, core_out.vector, core_out.read_data};

  // every input transfer lands in the input register
  `PIC_ASSERT_NEXT(a_in_loaded, in_tvalid && in_tready, in_valid_r)
  // every item taken by the core shows up as a result
  `PIC_ASSERT_NEXT(a_take_result, core_take, out_tvalid)
  // a buffered item that the core cannot take stays put
  `PIC_ASSERT_NEXT(a_buf_hold, in_valid_r && !core_take, in_valid_r && $stable(in_item_r))
  // the core only takes an item when the result register can accept it
  `PIC_ASSERT_SAME(a_take_room, core_take, !out_tvalid || out_tready)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the 8259-style interrupt controller: a directed table,
// then random bus traffic under several handshake idle patterns, checked by a predictor
// depends on pic8259_pkg and interrupt_controller_8259

module testbench;
  import pic8259_pkg::*;

  localparam int LINES = 8;
  localparam logic [7:0] LINE_MASK = 8'((1 << LINES) - 1);
  localparam int NO_GRANT = 8;
  localparam int RANDOM_ITEMS = 950;
  localparam int LONG_STALL = 300;
  localparam int DRAIN_CYCLES = 6;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // addr_bit [0], write_data [8:1], request_lines [16:9], zero fill above
  logic [IN_TDATA_W-1:0] in_tdata;
  // op [1:0]
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  // read_data [7:0], vector [15:8], int_out [16], zero fill above
  logic [OUT_TDATA_W-1:0] out_tdata;

  interrupt_controller_8259 #(.NUM_LINES(LINES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  typedef struct {
    item_t   it;
    bit      fixed;
    result_t want;
  } dir_row_t;

  // predicted controller state
  logic [7:0] req_latch;
  logic [7:0] isr_bits;
  logic [7:0] imr_bits;
  logic [7:0] cascade_byte;
  logic [7:0] last_lines;
  logic [4:0] vec_base;
  phase_t     init_step;
  logic       want_icw4;
  logic       single_pic;
  logic       read_isr;

  result_t awaited_replies[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      stall_requests = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int first_set(logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[i]) return i;
    end
    return NO_GRANT;
  endfunction

  // line an acknowledge would take now, NO_GRANT if none outranks in-service
  function automatic int grant_line();
    int p;
    int s;
    p = first_set(req_latch & ~imr_bits & LINE_MASK);
    s = first_set(isr_bits);
    return (p < s) ? p : NO_GRANT;
  endfunction

  // advance the predicted state by one item and return its reply
  function automatic result_t step_controller(item_t it);
    result_t r;
    logic [7:0] d;
    int g;
    r = '0;
    d = it.write_data;
    case (it.op)
      OP_READ: begin
        r.read_data = it.addr_bit ? imr_bits : (read_isr ? isr_bits : req_latch);
      end
      OP_WRITE: begin
        if (!it.addr_bit) begin
          if ((d & CMD_ICW1) != 0) begin
            init_step  = PH_ICW2;
            want_icw4  = (d & ICW1_NEED_ICW4) != 0;
            single_pic = (d & ICW1_SNGL) != 0;
            imr_bits   = '0;
            req_latch  = '0;
            isr_bits   = '0;
            read_isr   = 1'b0;
          end else if ((d & CMD_OCW3) != 0) begin
            if ((d & OCW3_RR) != 0) read_isr = (d & OCW3_SEL_ISR) != 0;
          end else if ((d & OCW2_KIND_MASK) == OCW2_SPEC_EOI) begin
            isr_bits[d[2:0]] = 1'b0;
          end
        end else begin
          case (init_step)
            PH_ICW2: begin
              vec_base  = d[7:3];
              init_step = single_pic ? (want_icw4 ? PH_ICW4 : PH_READY) : PH_ICW3;
            end
            PH_ICW3: begin
              cascade_byte = d;
              init_step    = want_icw4 ? PH_ICW4 : PH_READY;
            end
            PH_ICW4: init_step = PH_READY;
            default: imr_bits = d;
          endcase
        end
      end
      OP_LINES: begin
        // requests latch on rising edges only
        req_latch  = req_latch | ((it.request_lines & LINE_MASK) & ~last_lines);
        last_lines = it.request_lines & LINE_MASK;
      end
      default: begin
        g = grant_line();
        if (g != NO_GRANT) begin
          req_latch[g] = 1'b0;
          isr_bits[g]  = 1'b1;
          r.vector     = {vec_base, 3'(g)};
        end else begin
          r.vector = {vec_base, SPURIOUS_LINE};
        end
      end
    endcase
    r.int_out = grant_line() != NO_GRANT;
    return r;
  endfunction

  function automatic item_t bus_item(op_t op, logic a0, logic [7:0] d, logic [7:0] l);
    item_t it;
    it.op            = op;
    it.addr_bit      = a0;
    it.write_data    = d;
    it.request_lines = l;
    return it;
  endfunction

  function automatic dir_row_t dir_row(op_t op, logic a0, logic [7:0] d, logic [7:0] l,
                                       bit fixed, logic [7:0] rd, logic [7:0] vec,
                                       logic irq);
    dir_row_t row;
    row.it             = bus_item(op, a0, d, l);
    row.fixed          = fixed;
    row.want.read_data = rd;
    row.want.vector    = vec;
    row.want.int_out   = irq;
    return row;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // offer one item from a falling edge, return at the falling edge after its transfer
  task automatic send_item(item_t it, bit fixed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W - 17){1'b0}}, it.request_lines, it.write_data, it.addr_bit};
    in_tuser  = it.op;
    do @(posedge clk); while (!in_tready);
    predicted = step_controller(it);
    awaited_replies.push_back(fixed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_predicted(item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
  endtask

  // one random scenario; most are well-formed, a few are plain noise
  task automatic random_burst();
    int pick;
    logic [7:0] icw1;
    logic [7:0] lvl;
    logic [7:0] lines;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // mostly toggle a few lines so edges keep arriving
      lines = ($urandom_range(3) == 0) ? rand_byte() : last_lines ^ (rand_byte() & rand_byte());
      send_predicted(bus_item(OP_LINES, 1'($urandom), rand_byte(), lines));
    end else if (pick < 45) begin
      send_predicted(bus_item(OP_ACK, 1'($urandom), rand_byte(), rand_byte()));
    end else if (pick < 60) begin
      send_predicted(bus_item(OP_READ, $urandom_range(9) < 6 ? 1'b0 : 1'b1,
                              rand_byte(), rand_byte()));
    end else if (pick < 70) begin
      // specific eoi, usually for the highest-priority line in service
      if (isr_bits != 0 && $urandom_range(3) != 0) lvl = 8'(first_set(isr_bits));
      else lvl = 8'($urandom_range(7));
      send_predicted(bus_item(OP_WRITE, 1'b0, OCW2_SPEC_EOI | lvl, rand_byte()));
    end else if (pick < 78) begin
      // ocw3 with random rr/ris and don't-care bits
      send_predicted(bus_item(OP_WRITE, 1'b0, (rand_byte() & ~CMD_ICW1) | CMD_OCW3,
                              rand_byte()));
    end else if (pick < 86) begin
      send_predicted(bus_item(OP_WRITE, 1'b1,
                              $urandom_range(1) ? (rand_byte() & rand_byte() & rand_byte())
                                                : rand_byte(), rand_byte()));
    end else if (pick < 92) begin
      // full init sequence, sometimes with a stray access inside it
      icw1 = rand_byte() | CMD_ICW1;
      send_predicted(bus_item(OP_WRITE, 1'b0, icw1, rand_byte()));
      if ($urandom_range(4) == 0)
        send_predicted(bus_item(op_t'($urandom_range(1) ? OP_ACK : OP_READ),
                                1'($urandom), rand_byte(), rand_byte()));
      send_predicted(bus_item(OP_WRITE, 1'b1, rand_byte(), rand_byte()));
      if ((icw1 & ICW1_SNGL) == 0)
        send_predicted(bus_item(OP_WRITE, 1'b1, rand_byte(), rand_byte()));
      if ((icw1 & ICW1_NEED_ICW4) != 0)
        send_predicted(bus_item(OP_WRITE, 1'b1, rand_byte(), rand_byte()));
      send_predicted(bus_item(OP_WRITE, 1'b1, rand_byte() & rand_byte() & rand_byte(),
                              rand_byte()));
    end else begin
      send_predicted(bus_item(op_t'($urandom_range(3)), 1'($urandom), rand_byte(),
                              rand_byte()));
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int stall_served;
    stall_left   = 0;
    stall_served = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_requests != stall_served) begin
        stall_served = stall_requests;
        stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // compare every reply transfer with the oldest prediction
  always @(posedge clk) begin : check_replies
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data = out_tdata[7:0];
      got.vector    = out_tdata[15:8];
      got.int_out   = out_tdata[16];
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply rd=%02h vec=%02h int=%0b", $time,
                 got.read_data, got.vector, got.int_out);
      end else begin
        want = awaited_replies.pop_front();
        if (got.read_data !== want.read_data || got.vector !== want.vector ||
            got.int_out !== want.int_out) begin
          mismatches++;
          $display("%0t: mismatch expected rd=%02h vec=%02h int=%0b got rd=%02h vec=%02h int=%0b",
                   $time, want.read_data, want.vector, want.int_out,
                   got.read_data, got.vector, got.int_out);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    int       goal;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    req_latch    = '0;
    isr_bits     = '0;
    imr_bits     = '0;
    cascade_byte = '0;
    last_lines   = '0;
    vec_base     = '0;
    init_step    = PH_READY;
    want_icw4    = 1'b0;
    single_pic   = 1'b0;
    read_isr     = 1'b0;

    // directed part; fixed replies only where obvious from reset state
    rows.push_back(dir_row(OP_READ,  1'b0, 8'hff, 8'h00, 1, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_READ,  1'b1, 8'h00, 8'hff, 1, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_ACK,   1'b0, 8'h00, 8'h00, 1, 8'h00, 8'h07, 1'b0));
    rows.push_back(dir_row(OP_LINES, 1'b0, 8'h00, 8'hff, 0, 8'h00, 8'h00, 1'b0));
    // icw1 single, with icw4: clears the request just latched
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h13, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_READ,  1'b1, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_ACK,   1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'hff, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'hff, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_LINES, 1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_LINES, 1'b1, 8'hff, 8'hff, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_READ,  1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_ACK,   1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    // ocw3 read in-service, then an ack blocked by line 0 in service
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h0b, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_READ,  1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_ACK,   1'b1, 8'hff, 8'hff, 0, 8'h00, 8'h00, 1'b0));
    // non-specific eoi and ocw3 without rr are ignored
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h20, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h08, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h60, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'hff, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_ACK,   1'b0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    // cascaded init without icw4: icw2, icw3, then back to mask writes
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h10, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'h00, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'ha5, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b1, 8'h55, 8'h00, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(dir_row(OP_WRITE, 1'b0, 8'h67, 8'h00, 0, 8'h00, 8'h00, 1'b0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].want);

    // random traffic in four idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) stall_requests++;
      // sender pause until every reply is back
      if (ph == 3) wait_drained();
      goal = rows.size() + (ph + 1) * RANDOM_ITEMS / 4;
      while (items_sent < goal) random_burst();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
